FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the FAT entry block.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/fat_eld_pkg.sv
// Types and constants for the FAT entry locate/decode block.
// Depends on nothing.
`default_nettype none

package fat_eld_pkg;

    typedef enum logic [1:0] {
        FAT12 = 2'd0,
        FAT16 = 2'd1,
        FAT32 = 2'd2
    } t_fat_kind;

    typedef enum logic [2:0] {
        REG_SECTOR_SIZE_LOG2  = 3'd0,
        REG_CLUSTER_SIZE_LOG2 = 3'd1,
        REG_RESERVED_SECTORS  = 3'd2,
        REG_TOTAL_SMALL       = 3'd3,
        REG_TOTAL_LARGE       = 3'd4
    } t_reg_index;

    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_INDEX_W  = 3;

    localparam logic [31:0] FAT32_MIN_CLUSTERS = 32'd65536;
    localparam logic [31:0] FAT16_MIN_CLUSTERS = 32'd4096;

    localparam logic [3:0]  SLOG_MIN  = 4'd9;
    localparam logic [3:0]  SLOG_MAX  = 4'd12;

    localparam logic [11:0] FAT12_EOC_MIN = 12'hff0;
    localparam logic [15:0] FAT16_EOC_MIN = 16'hfff0;
    localparam logic [31:0] FAT12_EOC_EXT = 32'h0ffff000;
    localparam logic [31:0] FAT16_EOC_EXT = 32'h0fff0000;
    localparam logic [31:0] FAT32_MASK    = 32'h0fffffff;

endpackage

`default_nettype wire

FILE: design/fat_entry_locate_decode.sv
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the output is not stalled; the path is a 34-bit add,
// three barrel shifts, compares and a 32-bit add.
// Reset (synchronous, active low) empties both stages and loads the register defaults:
// sector size log2 9, cluster size log2 0, reserved sectors 1, both totals 0.
// FAT cluster-chain entry locate and decode; depends on fat_eld_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fat_entry_locate_decode (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [fat_eld_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [fat_eld_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_op,
    input  wire logic [31:0]                         i_cluster,
    input  wire logic [31:0]                         i_entry_bytes,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [31:0]                              o_fat_sector,
    output logic [11:0]                              o_byte_offset,
    output logic                                     o_crosses_sector,
    output logic [1:0]                               o_fat_kind,
    output logic [31:0]                              o_next_cluster,
    output logic                                     o_status
);
    import fat_eld_pkg::*;

    logic [3:0]  r_sector_size_log2;
    logic [2:0]  r_cluster_size_log2;
    logic [15:0] r_reserved_sectors;
    logic [15:0] r_total_small;
    logic [31:0] r_total_large;

    logic        r_s1_valid;
    logic        r_s1_op;
    logic [31:0] r_s1_cluster;
    logic [31:0] r_s1_bytes;

    logic        r_out_valid;
    logic [31:0] r_fat_sector;
    logic [11:0] r_byte_offset;
    logic        r_crosses;
    t_fat_kind   r_kind;
    logic [31:0] r_next_cluster;
    logic        r_status;

    logic        s2_load;
    logic        s1_load;

    logic [3:0]  slog;
    logic [31:0] total;
    logic [31:0] nclus;
    t_fat_kind   kind;
    logic [33:0] pos;
    logic [33:0] off_mask;
    logic [31:0] sec_idx;
    logic [11:0] offset;
    logic        crosses;
    logic [11:0] f12;
    logic [31:0] dec;
    logic        beyond;

    logic [31:0] n_fat_sector;
    logic [11:0] n_byte_offset;
    logic        n_crosses;
    logic [31:0] n_next_cluster;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_size_log2  <= 4'd9;
            r_cluster_size_log2 <= 3'd0;
            r_reserved_sectors  <= 16'd1;
            r_total_small       <= 16'd0;
            r_total_large       <= 32'd0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_SECTOR_SIZE_LOG2:  r_sector_size_log2  <= i_cfg_data[3:0];
                REG_CLUSTER_SIZE_LOG2: r_cluster_size_log2 <= i_cfg_data[2:0];
                REG_RESERVED_SECTORS:  r_reserved_sectors  <= i_cfg_data[15:0];
                REG_TOTAL_SMALL:       r_total_small       <= i_cfg_data[15:0];
                REG_TOTAL_LARGE:       r_total_large       <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign s2_load    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_load    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_op      <= i_op;
            r_s1_cluster <= i_cluster;
            r_s1_bytes   <= i_entry_bytes;
        end
    end

    // locate and decode
    always_comb begin
        if (r_sector_size_log2 < SLOG_MIN) begin
            slog = SLOG_MIN;
        end else if (r_sector_size_log2 > SLOG_MAX) begin
            slog = SLOG_MAX;
        end else begin
            slog = r_sector_size_log2;
        end

        total = (r_total_large != 32'd0) ? r_total_large : {16'd0, r_total_small};
        nclus = total >> r_cluster_size_log2;

        if (nclus >= FAT32_MIN_CLUSTERS) begin
            kind = FAT32;
        end else if (nclus >= FAT16_MIN_CLUSTERS) begin
            kind = FAT16;
        end else begin
            kind = FAT12;
        end

        case (kind)
            FAT32:   pos = {r_s1_cluster, 2'b00};
            FAT16:   pos = {1'b0, r_s1_cluster, 1'b0};
            default: pos = ({2'b00, r_s1_cluster} + {1'b0, r_s1_cluster, 1'b0}) >> 1;
        endcase

        off_mask = (34'd1 << slog) - 34'd1;
        sec_idx  = 32'(pos >> slog);
        offset   = pos[11:0] & off_mask[11:0];
        crosses  = (kind == FAT12) && (offset == off_mask[11:0]);

        // odd FAT12 entries start at the high nibble of byte 0
        f12 = r_s1_cluster[0] ? r_s1_bytes[15:4] : r_s1_bytes[11:0];
        case (kind)
            FAT32:   dec = r_s1_bytes & FAT32_MASK;
            FAT16:   dec = (r_s1_bytes[15:0] >= FAT16_EOC_MIN)
                           ? ({16'd0, r_s1_bytes[15:0]} | FAT16_EOC_EXT)
                           : {16'd0, r_s1_bytes[15:0]};
            default: dec = (f12 >= FAT12_EOC_MIN) ? ({20'd0, f12} | FAT12_EOC_EXT)
                                                  : {20'd0, f12};
        endcase

        beyond = r_s1_cluster > nclus;

        if (beyond) begin
            n_fat_sector   = 32'd0;
            n_byte_offset  = 12'd0;
            n_crosses      = 1'b0;
            n_next_cluster = 32'hffffffff;
        end else begin
            n_fat_sector   = sec_idx + {16'd0, r_reserved_sectors};
            n_byte_offset  = offset;
            n_crosses      = crosses;
            n_next_cluster = r_s1_op ? dec : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_fat_sector   <= n_fat_sector;
            r_byte_offset  <= n_byte_offset;
            r_crosses      <= n_crosses;
            r_kind         <= kind;
            r_next_cluster <= n_next_cluster;
            r_status       <= beyond;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fat_sector     = r_fat_sector;
    assign o_byte_offset    = r_byte_offset;
    assign o_crosses_sector = r_crosses;
    assign o_fat_kind       = r_kind;
    assign o_next_cluster   = r_next_cluster;
    assign o_status         = r_status;

    `ASSERT_IMPLY(a_err_fields, i_clk, i_rst_n, r_out_valid && r_status,
                  r_next_cluster == 32'hffffffff && r_fat_sector == 32'd0 && !r_crosses)
    `ASSERT_IMPLY(a_cross_fat12, i_clk, i_rst_n, r_out_valid && r_crosses, r_kind == FAT12)
    `ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_out_valid)
    `ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, s2_load, r_out_valid)

endmodule

`default_nettype wire
